// ===== hw/rtl/swsfd_pkg.sv =====
package swsfd_pkg;

  // capture counter and register widths
  localparam int TIME_WIDTH = 16;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 2;

  // frame layout
  localparam int FRAME_BITS = 40;
  localparam int BYTE_WIDTH = 8;
  localparam int EDGE_INDEX_WIDTH = 6;
  localparam logic [EDGE_INDEX_WIDTH-1:0] REF_EDGE = EDGE_INDEX_WIDTH'(1);
  localparam logic [EDGE_INDEX_WIDTH-1:0] FIRST_BIT_EDGE = EDGE_INDEX_WIDTH'(2);
  localparam logic [EDGE_INDEX_WIDTH-1:0] LAST_BIT_EDGE =
    EDGE_INDEX_WIDTH'(FIRST_BIT_EDGE + FRAME_BITS - 1);
  localparam logic [EDGE_INDEX_WIDTH-1:0] DONE_EDGE =
    EDGE_INDEX_WIDTH'(FIRST_BIT_EDGE + FRAME_BITS);

  // input op codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  // register reset values
  localparam logic [CFG_DATA_WIDTH-1:0] WIDTH_OFFSET_RESET = CFG_DATA_WIDTH'(50);
  localparam logic [CFG_DATA_WIDTH-1:0] ONE_THRESHOLD_RESET = CFG_DATA_WIDTH'(35);

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_WIDTH_OFFSET  = 2'd0,
    REG_ONE_THRESHOLD = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_REF      = 2'd0,
    KIND_BIT      = 2'd1,
    KIND_LAST_BIT = 2'd2
  } edge_kind_e;

  typedef struct packed {
    edge_kind_e            kind;
    logic [TIME_WIDTH-1:0] ts;
  } edge_entry_t;

  typedef struct packed {
    logic [CFG_DATA_WIDTH-1:0] width_offset;
    logic [CFG_DATA_WIDTH-1:0] one_threshold;
  } cfg_t;

endpackage

// ===== hw/rtl/swsfd_front.sv =====
module swsfd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [swsfd_pkg::TIME_WIDTH-1:0] timestamp,
  input  logic                          q_full,
  output logic                          push,
  output swsfd_pkg::edge_entry_t        push_entry
);
  import swsfd_pkg::*;

  logic                        armed, armed_next;
  logic [EDGE_INDEX_WIDTH-1:0] edge_index, edge_index_next;
  logic                        accept;

  assign in_stall = q_full;
  assign accept = in_valid && !q_full;

  // start arms, discard first edge, tag the rest for the back end
  always_comb begin
    armed_next = armed;
    edge_index_next = edge_index;
    push = 1'b0;
    push_entry.kind = KIND_BIT;
    push_entry.ts = timestamp;
    if (accept) begin
      if (op == OP_START) begin
        armed_next = 1'b1;
        edge_index_next = '0;
      end else if (armed) begin
        edge_index_next = edge_index + EDGE_INDEX_WIDTH'(1);
        if (edge_index == REF_EDGE) begin
          push = 1'b1;
          push_entry.kind = KIND_REF;
        end else if (edge_index == LAST_BIT_EDGE) begin
          push = 1'b1;
          push_entry.kind = KIND_LAST_BIT;
          armed_next = 1'b0;
        end else if (edge_index != '0) begin
          push = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
      edge_index <= '0;
    end else begin
      armed <= armed_next;
      edge_index <= edge_index_next;
    end
  end

endmodule

// ===== hw/rtl/swsfd_queue.sv =====
module swsfd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  swsfd_pkg::edge_entry_t push_entry,
  output logic                   full,
  input  logic                   pop,
  output logic                   empty,
  output swsfd_pkg::edge_entry_t head
);
  import swsfd_pkg::*;

  edge_entry_t                entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_WIDTH-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_WIDTH:0]   count;
  logic                       do_push, do_pop;

  assign full = (count == (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_WIDTH'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_WIDTH'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (QUEUE_PTR_WIDTH+1)'(1);
        2'b01:   count <= count - (QUEUE_PTR_WIDTH+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/swsfd_back.sv =====
module swsfd_back (
  input  logic                                clk,
  input  logic                                rst,
  input  swsfd_pkg::cfg_t                     cfg,
  input  logic                                q_empty,
  input  swsfd_pkg::edge_entry_t              head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [swsfd_pkg::BYTE_WIDTH-1:0]    humidity_whole,
  output logic [swsfd_pkg::BYTE_WIDTH-1:0]    humidity_frac,
  output logic [swsfd_pkg::BYTE_WIDTH-1:0]    temperature_whole,
  output logic [swsfd_pkg::BYTE_WIDTH-1:0]    temperature_frac,
  output logic [swsfd_pkg::BYTE_WIDTH-1:0]    check_byte,
  output logic                                check_ok
);
  import swsfd_pkg::*;

  logic [TIME_WIDTH-1:0] last_edge_time;
  logic [FRAME_BITS-1:0] frame_shift;
  logic [TIME_WIDTH-1:0] period;
  logic                  bit_value;
  logic [FRAME_BITS-1:0] frame_next;
  logic [BYTE_WIDTH-1:0] byte_sum, sum_minus_one, chk_next;

  // output register free or emptying this cycle
  assign pop = !q_empty && (!out_valid || !out_stall);

  assign period = head.ts - last_edge_time - TIME_WIDTH'(cfg.width_offset);
  assign bit_value = (period > TIME_WIDTH'(cfg.one_threshold));
  assign frame_next = {frame_shift[FRAME_BITS-2:0], bit_value};

  // data bytes already sit in the old shift, so the sum runs beside the compare
  assign byte_sum = frame_next[39:32] + frame_next[31:24]
                  + frame_next[23:16] + frame_next[15:8];
  assign sum_minus_one = byte_sum - BYTE_WIDTH'(1);
  assign chk_next = frame_next[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
      frame_shift <= '0;
      humidity_whole <= '0;
      humidity_frac <= '0;
      temperature_whole <= '0;
      temperature_frac <= '0;
      check_byte <= '0;
      check_ok <= 1'b0;
    end else if (pop) begin
      last_edge_time <= head.ts;
      if (head.kind != KIND_REF) begin
        frame_shift <= frame_next;
      end
      if (head.kind == KIND_LAST_BIT) begin
        humidity_whole <= frame_next[39:32];
        humidity_frac <= frame_next[31:24];
        temperature_whole <= frame_next[23:16];
        temperature_frac <= frame_next[15:8];
        check_byte <= chk_next;
        check_ok <= (chk_next == byte_sum) || (chk_next == sum_minus_one);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head.kind == KIND_LAST_BIT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    pop |-> !(out_valid && out_stall))
    else $error("back end popped while a result was held");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (pop && head.kind == KIND_LAST_BIT) |=> out_valid)
    else $error("last bit did not load a result");

  a_ref_keeps_shift: assert property (@(posedge clk) disable iff (rst)
    (pop && head.kind == KIND_REF) |=> $stable(frame_shift))
    else $error("reference edge disturbed the frame shift");
`endif

endmodule

// ===== hw/rtl/single_wire_sensor_frame_decoder.sv =====
// a frame's result goes valid when the queue entry written for its last edge is popped
// into the back-end result register, which waits while a held result is stalled
// throughput: one input transaction per cycle, set by the single subtract and
// compare in the back end; a full four-entry queue stalls the input
// reset (rst, synchronous, active high) disarms the decoder, empties the queue,
// drops any held result and loads width_offset = 50, one_threshold = 35
module single_wire_sensor_frame_decoder (
  input  logic                                    clk,
  input  logic                                    rst,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    op,
  input  logic [swsfd_pkg::TIME_WIDTH-1:0]        timestamp,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [swsfd_pkg::BYTE_WIDTH-1:0]        humidity_whole,
  output logic [swsfd_pkg::BYTE_WIDTH-1:0]        humidity_frac,
  output logic [swsfd_pkg::BYTE_WIDTH-1:0]        temperature_whole,
  output logic [swsfd_pkg::BYTE_WIDTH-1:0]        temperature_frac,
  output logic [swsfd_pkg::BYTE_WIDTH-1:0]        check_byte,
  output logic                                    check_ok,
  // register write channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [swsfd_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [swsfd_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
  import swsfd_pkg::*;

  cfg_t        cfg;
  logic        push, pop, q_full, q_empty;
  edge_entry_t push_entry, head;

  // register writes are always accepted
  assign cfg_ready = 1'b1;

  // register file; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_offset <= WIDTH_OFFSET_RESET;
      cfg.one_threshold <= ONE_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH_OFFSET:  cfg.width_offset <= cfg_data;
        REG_ONE_THRESHOLD: cfg.one_threshold <= cfg_data;
        default:           cfg <= cfg;
      endcase
    end
  end

  // front: tracks arming and edge count, drops starts and ignored edges,
  // tags each remaining edge as reference, data bit or final bit
  swsfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .timestamp  (timestamp),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // short queue lets the front keep taking edges while a result waits
  swsfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head       (head)
  );

  // back: period math, bit shift-in, frame assembly and checksum
  swsfd_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .q_empty           (q_empty),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .humidity_whole    (humidity_whole),
    .humidity_frac     (humidity_frac),
    .temperature_whole (temperature_whole),
    .temperature_frac  (temperature_frac),
    .check_byte        (check_byte),
    .check_ok          (check_ok)
  );

endmodule

// ===== dv/single_wire_sensor_frame_decoder_tb.sv =====
`timescale 1ns / 1ps

module single_wire_sensor_frame_decoder_tb;
  import swsfd_pkg::*;

  // run shape
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 160;
  localparam int MIN_FRAMES = 20;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_PRINTED = 40;

  // one decoded frame as it leaves the block
  typedef struct packed {
    logic [BYTE_WIDTH-1:0] humidity_whole;
    logic [BYTE_WIDTH-1:0] humidity_frac;
    logic [BYTE_WIDTH-1:0] temperature_whole;
    logic [BYTE_WIDTH-1:0] temperature_frac;
    logic [BYTE_WIDTH-1:0] check_byte;
    logic                  check_ok;
  } frame_t;

  // tracks the decoder state, predicts finished frames and matches them
  class frame_tracker;
    logic [TIME_WIDTH-1:0]       width_offset;
    logic [TIME_WIDTH-1:0]       one_threshold;
    logic [TIME_WIDTH-1:0]       last_edge;
    logic [EDGE_INDEX_WIDTH-1:0] edge_count;
    logic [FRAME_BITS-1:0]       bits;
    bit                          armed;
    frame_t                      pending_frames[$];
    int                          errors;
    int                          checked;

    function new();
      width_offset  = WIDTH_OFFSET_RESET;
      one_threshold = ONE_THRESHOLD_RESET;
      last_edge     = '0;
      edge_count    = '0;
      bits          = '0;
      armed         = 1'b0;
      errors        = 0;
      checked       = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_WIDTH-1:0] value);
      case (idx)
        REG_WIDTH_OFFSET:  width_offset = value;
        REG_ONE_THRESHOLD: one_threshold = value;
        default: ;
      endcase
    endfunction

    // one accepted input transaction
    function void take_item(logic item_op, logic [TIME_WIDTH-1:0] ts);
      logic [TIME_WIDTH-1:0] period;
      logic [BYTE_WIDTH-1:0] sum;
      frame_t                f;
      if (item_op == OP_START) begin
        armed      = 1'b1;
        edge_count = '0;
        bits       = '0;
        return;
      end
      if (!armed) return;
      // first edge is the sensor's response, second sets the reference
      if (edge_count == '0) begin
        edge_count = REF_EDGE;
        return;
      end
      if (edge_count == REF_EDGE) begin
        last_edge  = ts;
        edge_count = FIRST_BIT_EDGE;
        return;
      end
      period     = ts - last_edge - width_offset;
      bits       = {bits[FRAME_BITS-2:0], period > one_threshold};
      last_edge  = ts;
      edge_count = edge_count + 1'b1;
      if (edge_count >= DONE_EDGE) begin
        {f.humidity_whole, f.humidity_frac, f.temperature_whole, f.temperature_frac,
         f.check_byte} = bits;
        sum = f.humidity_whole + f.humidity_frac + f.temperature_whole + f.temperature_frac;
        f.check_ok = (f.check_byte == sum) || (f.check_byte == sum - 8'd1);
        pending_frames.push_back(f);
        armed = 1'b0;
      end
    endfunction

    // one accepted result transaction
    function void take_result(frame_t got);
      frame_t want;
      checked++;
      if (pending_frames.size() == 0) begin
        report($sformatf("frame %h with none expected", got));
        return;
      end
      want = pending_frames.pop_front();
      if (got.humidity_whole !== want.humidity_whole)
        report($sformatf("humidity_whole %h, want %h", got.humidity_whole,
                         want.humidity_whole));
      if (got.humidity_frac !== want.humidity_frac)
        report($sformatf("humidity_frac %h, want %h", got.humidity_frac,
                         want.humidity_frac));
      if (got.temperature_whole !== want.temperature_whole)
        report($sformatf("temperature_whole %h, want %h", got.temperature_whole,
                         want.temperature_whole));
      if (got.temperature_frac !== want.temperature_frac)
        report($sformatf("temperature_frac %h, want %h", got.temperature_frac,
                         want.temperature_frac));
      if (got.check_byte !== want.check_byte)
        report($sformatf("check_byte %h, want %h", got.check_byte, want.check_byte));
      if (got.check_ok !== want.check_ok)
        report($sformatf("check_ok %b, want %b", got.check_ok, want.check_ok));
    endfunction
  endclass

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic                        op;
  logic [TIME_WIDTH-1:0]       timestamp;
  logic                        out_valid;
  logic                        out_stall;
  logic [BYTE_WIDTH-1:0]       humidity_whole;
  logic [BYTE_WIDTH-1:0]       humidity_frac;
  logic [BYTE_WIDTH-1:0]       temperature_whole;
  logic [BYTE_WIDTH-1:0]       temperature_frac;
  logic [BYTE_WIDTH-1:0]       check_byte;
  logic                        check_ok;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0]  cfg_index;
  logic [CFG_DATA_WIDTH-1:0]   cfg_data;

  frame_tracker          frames = new();
  int                    cycles;
  int                    items_sent;
  int                    gap_pct;
  int                    stall_pct;
  bit                    quiet;
  // register values the stimulus shapes its periods around
  logic [TIME_WIDTH-1:0] cur_offset;
  logic [TIME_WIDTH-1:0] cur_thresh;

  single_wire_sensor_frame_decoder u_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .op                (op),
    .timestamp         (timestamp),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .humidity_whole    (humidity_whole),
    .humidity_frac     (humidity_frac),
    .temperature_whole (temperature_whole),
    .temperature_frac  (temperature_frac),
    .check_byte        (check_byte),
    .check_ok          (check_ok),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung handshake or a lost frame ends here
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // every transaction is observed at the rising edge, before the block updates
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) frames.write_reg(cfg_reg_e'(cfg_index), cfg_data);
      if (in_valid && !in_stall) frames.take_item(op, timestamp);
      if (out_valid && !out_stall)
        frames.take_result({humidity_whole, humidity_frac, temperature_whole,
                            temperature_frac, check_byte, check_ok});
    end
  end

  // receiver back-pressure in bursts of random length
  always begin
    @(negedge clk);
    if (!rst && !quiet && $urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(14, 1)) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  // one input transaction; valid stays high on return so back-to-back items
  // need no extra assignment, an optional gap lowers it first
  task automatic send_item(input logic item_op, input logic [TIME_WIDTH-1:0] ts,
                           input bit live = 1'b1);
    if (!quiet && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    op        <= item_op;
    timestamp <= ts;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (live) items_sent++;
  endtask

  // sender holds off until every predicted frame has come out, then lets the
  // edges that make no frame clear the pipeline
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (frames.pending_frames.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // both registers in one burst, block must be idle
  task automatic write_config(input logic [CFG_DATA_WIDTH-1:0] offset_val,
                              input logic [CFG_DATA_WIDTH-1:0] thresh_val);
    cfg_valid <= 1'b1;
    cfg_index <= REG_WIDTH_OFFSET;
    cfg_data  <= offset_val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= REG_ONE_THRESHOLD;
    cfg_data  <= thresh_val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid  <= 1'b0;
    cur_offset = offset_val;
    cur_thresh = thresh_val;
  endtask

  // four data bytes plus a check byte that is right, one low, one high or junk
  function automatic logic [FRAME_BITS-1:0] make_frame();
    logic [BYTE_WIDTH-1:0] d[4];
    logic [BYTE_WIDTH-1:0] sum;
    logic [BYTE_WIDTH-1:0] chk;
    int                    mode;
    mode = $urandom_range(7);
    for (int k = 0; k < 4; k++)
      d[k] = (mode == 0) ? 8'h00 : (mode == 1) ? 8'hFF : 8'($urandom);
    sum = d[0] + d[1] + d[2] + d[3];
    case ($urandom_range(3))
      0:       chk = sum;
      1:       chk = sum - 8'd1;
      2:       chk = sum + 8'd1;
      default: chk = 8'($urandom);
    endcase
    return {d[0], d[1], d[2], d[3], chk};
  endfunction

  // start, response edge, reference edge, then n_bits data edges whose periods
  // straddle the threshold; short n_bits leaves a frame hanging
  task automatic send_frame(input logic [FRAME_BITS-1:0] payload, input int n_bits);
    logic [TIME_WIDTH-1:0] t;
    logic [TIME_WIDTH-1:0] p;
    bit                    one;
    send_item(OP_START, TIME_WIDTH'($urandom));
    send_item(OP_EDGE, TIME_WIDTH'($urandom));
    t = TIME_WIDTH'($urandom);
    send_item(OP_EDGE, t);
    for (int i = 0; i < n_bits; i++) begin
      one = payload[FRAME_BITS-1-i];
      if (one && cur_thresh == '1) begin
        // no period can decode as one at this threshold
        p = TIME_WIDTH'($urandom);
      end else if (one) begin
        case ($urandom_range(3))
          0:       p = cur_thresh + 1'b1;
          1:       p = '1;
          2:       p = TIME_WIDTH'($urandom_range(32'(cur_thresh) + 40, 32'(cur_thresh) + 1));
          default: p = TIME_WIDTH'($urandom_range(32'hFFFF, 32'(cur_thresh) + 1));
        endcase
      end else begin
        case ($urandom_range(3))
          0:       p = '0;
          1:       p = cur_thresh;
          default: p = TIME_WIDTH'($urandom_range(32'(cur_thresh), 0));
        endcase
      end
      // adjusted period plus offset gives the raw edge spacing, wrapping freely
      t = t + p + cur_offset;
      send_item(OP_EDGE, t);
    end
  endtask

  initial begin
    logic [CFG_DATA_WIDTH-1:0] offsets[PHASES];
    logic [CFG_DATA_WIDTH-1:0] thresholds[PHASES];
    int                        phase_start;
    int                        pick;

    // register settings per phase, extremes among them; phase 0 keeps reset values
    offsets    = '{16'd50, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'($urandom), 16'd1000, 16'd50};
    thresholds = '{16'd35, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'($urandom), 16'd200, 16'd35};

    clk        = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    op         = OP_START;
    timestamp  = '0;
    out_stall  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_WIDTH_OFFSET;
    cfg_data   = '0;
    cycles     = 0;
    items_sent = 0;
    gap_pct    = 0;
    stall_pct  = 0;
    quiet      = 1'b0;
    cur_offset = WIDTH_OFFSET_RESET;
    cur_thresh = ONE_THRESHOLD_RESET;

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: edges while disarmed are dropped
    send_item(OP_EDGE, 16'h0000);
    send_item(OP_EDGE, 16'hFFFF);
    // start, response edge, reference just below the counter wrap
    send_item(OP_START, 16'hFFFF);
    send_item(OP_EDGE, 16'hFFFF);
    send_item(OP_EDGE, 16'hFFF0);
    // period shorter than the offset wraps to a large value
    send_item(OP_EDGE, 16'h0005);
    // exactly on the threshold is a zero, one above is a one
    send_item(OP_EDGE, 16'h0005 + cur_offset + cur_thresh);
    send_item(OP_EDGE, 16'h0005 + 16'd2 * cur_offset + 16'd2 * cur_thresh + 16'd1);
    // start mid-frame drops it, and a second start right after
    send_item(OP_START, 16'h0000);
    send_item(OP_START, 16'hA5A5);
    send_item(OP_EDGE, 16'h0000);
    send_item(OP_EDGE, 16'h0000);
    // zero spacing also wraps under the offset
    send_item(OP_EDGE, 16'h0000);
    send_item(OP_EDGE, 16'h5A5A);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        write_config(offsets[ph], thresholds[ph]);
      end
      // some phases run flat out, the last one has no idling at all
      quiet     = (ph == PHASES - 1);
      gap_pct   = (ph % 3 == 0) ? 0 : $urandom_range(35, 5);
      stall_pct = (ph % 4 == 0) ? 0 : $urandom_range(15, 3);
      phase_start = items_sent;
      while ((items_sent - phase_start) < PHASE_ITEMS ||
             (ph == PHASES - 1 && frames.checked < MIN_FRAMES)) begin
        pick = $urandom_range(99);
        if (pick < 72) begin
          send_frame(make_frame(), FRAME_BITS);
        end else if (pick < 84) begin
          send_frame(make_frame(), $urandom_range(FRAME_BITS - 1, 0));
        end else if (pick < 92) begin
          repeat ($urandom_range(3, 1)) send_item(1'($urandom), TIME_WIDTH'($urandom));
        end else if (pick < 97) begin
          // trailing edges after a complete frame are ignored
          send_frame(make_frame(), FRAME_BITS);
          repeat ($urandom_range(3, 1)) send_item(OP_EDGE, TIME_WIDTH'($urandom), 1'b0);
        end else begin
          wait_drained();
        end
      end
    end

    in_valid <= 1'b0;
    while (frames.pending_frames.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (frames.errors == 0 && frames.pending_frames.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
